[design/assert_macros.svh]
// Assertion helpers for the RTL files; the queue core includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error(msg);

// The consequent must hold in the clock after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// The consequent must hold in the same clock as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

`endif

[design/sjfq_pkg.sv]
`default_nettype none

package sjfq_pkg;

    // Queue geometry and field widths.
    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int OCC_W = 5;
    localparam int TAG_W = 16;
    localparam int LEN_W = 32;
    localparam int ST_W  = 2;

    // Operation codes.
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // Status codes.
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

    // One held job.
    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [LEN_W-1:0] len;
    } t_entry;

    // Control broadcast from the top level to every cell.
    typedef struct packed {
        logic   push_en;
        logic   pop_en;
        t_entry new_job;
    } t_cell_ctl;

endpackage

`default_nettype wire

[design/shortest_job_first_queue_core.sv]
`default_nettype none

// Shortest-job-first queue: a word is accepted on any clock where start is
// high, since busy never rises, so one push or pop enters every cycle. Each
// word yields exactly one result word on the next clock, flagged by o_done for
// a single cycle; the receiver cannot stall, so it must take the result on
// that cycle. This speed comes from the row of cells: every cell
// compares its length with the pushed key in parallel and moves its entry one
// place in the same clock. Pushes to a full queue return the full status and
// pops on an empty queue return the empty status, leaving the queue as is.
module shortest_job_first_queue_core (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               start,
    output logic                              busy,
    input  wire                               i_opcode,
    input  wire  [sjfq_pkg::TAG_W-1:0]        i_job_tag,
    input  wire  [sjfq_pkg::LEN_W-1:0]        i_job_length,
    output logic                              o_done,
    output logic [sjfq_pkg::ST_W-1:0]         o_status,
    output logic [sjfq_pkg::TAG_W-1:0]        o_out_tag,
    output logic [sjfq_pkg::LEN_W-1:0]        o_out_length,
    output logic [sjfq_pkg::OCC_W-1:0]        o_occupancy
);

    localparam int D = sjfq_pkg::DEPTH;
    localparam int W = sjfq_pkg::CNT_W;

    logic                      accept;
    logic                      is_push;
    logic                      full;
    logic                      empty;
    sjfq_pkg::t_cell_ctl       ctl;
    logic [D-1:0]              keep;
    sjfq_pkg::t_entry          entry [D];

    logic [W-1:0]              r_count;
    logic [W-1:0]              n_count;
    logic                      r_done;
    logic [sjfq_pkg::ST_W-1:0] r_status;
    logic [sjfq_pkg::ST_W-1:0] n_status;
    sjfq_pkg::t_entry          r_out;
    sjfq_pkg::t_entry          n_out;

    // The queue takes a word on every clock.
    assign busy    = 1'b0;
    assign accept  = start && !busy;
    assign is_push = (i_opcode == sjfq_pkg::OP_PUSH);
    assign full    = (r_count == W'(D));
    assign empty   = (r_count == '0);

    // Broadcast control to the cells.
    always_comb begin
        ctl.push_en     = accept && is_push && !full;
        ctl.pop_en      = accept && !is_push && !empty;
        ctl.new_job.tag = i_job_tag;
        ctl.new_job.len = i_job_length;
    end

    // Row of cells, head in cell 0.
    for (genvar gi = 0; gi < D; gi++) begin : g_cell
        localparam logic [W-1:0] IDX = W'(gi);
        logic             prev_keep;
        sjfq_pkg::t_entry prev_entry;
        sjfq_pkg::t_entry next_entry;

        if (gi == 0) begin : g_head
            assign prev_keep  = 1'b1;
            assign prev_entry = ctl.new_job;
        end else begin : g_body
            assign prev_keep  = keep[gi-1];
            assign prev_entry = entry[gi-1];
        end

        if (gi == D - 1) begin : g_tail
            assign next_entry = entry[gi];
        end else begin : g_inner
            assign next_entry = entry[gi+1];
        end

        sjfq_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (ctl),
            .i_occupied   (IDX < r_count),
            .i_prev_keep  (prev_keep),
            .i_prev_entry (prev_entry),
            .i_next_entry (next_entry),
            .o_keep       (keep[gi]),
            .o_entry      (entry[gi])
        );
    end

    // Occupancy and result word.
    always_comb begin
        n_count  = r_count;
        n_status = sjfq_pkg::ST_OK;
        n_out    = '0;
        if (is_push) begin
            if (full) begin
                n_status = sjfq_pkg::ST_FULL;
            end else begin
                n_count = r_count + W'(1);
            end
        end else begin
            if (empty) begin
                n_status = sjfq_pkg::ST_EMPTY;
            end else begin
                n_count = r_count - W'(1);
                n_out   = entry[0];
            end
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= accept;
            if (accept) begin
                r_count <= n_count;
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
            r_out    <= n_out;
        end
    end

    assign o_done       = r_done;
    assign o_status     = r_status;
    assign o_out_tag    = r_out.tag;
    assign o_out_length = r_out.len;
    assign o_occupancy  = sjfq_pkg::OCC_W'(r_count);

`include "assert_macros.svh"

    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= W'(D), "count above depth")
    `ASSERT_NEXT(a_push_grows, i_clk, i_rst_n, ctl.push_en, r_count == $past(r_count) + W'(1), "push did not grow count")
    `ASSERT_NEXT(a_pop_empty, i_clk, i_rst_n, accept && !is_push && empty, o_status == sjfq_pkg::ST_EMPTY && r_count == '0, "bad empty pop result")
    `ASSERT_SAME(a_zero_on_fail, i_clk, i_rst_n, o_done && o_status != sjfq_pkg::ST_OK, o_out_tag == '0 && o_out_length == '0, "nonzero payload on failed word")

endmodule

`default_nettype wire

[design/sjfq_cell.sv]
`default_nettype none

// One slot of the sorted chain. It compares its own length with the pushed
// key and, together with its upstream neighbor's decision, picks its next
// content: hold, take the new job, take the upstream entry or take the
// downstream entry.
module sjfq_cell (
    input  wire                  i_clk,
    input  sjfq_pkg::t_cell_ctl  i_ctl,
    input  wire                  i_occupied,
    input  wire                  i_prev_keep,
    input  sjfq_pkg::t_entry     i_prev_entry,
    input  sjfq_pkg::t_entry     i_next_entry,
    output logic                 o_keep,
    output sjfq_pkg::t_entry     o_entry
);

    sjfq_pkg::t_entry r_entry;
    sjfq_pkg::t_entry n_entry;

    // An occupied entry that is not longer than the new job stays ahead of it.
    assign o_keep = i_occupied && (r_entry.len <= i_ctl.new_job.len);

    // Next content of the slot.
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.pop_en) begin
            n_entry = i_next_entry;
        end else if (i_ctl.push_en && !o_keep) begin
            if (i_prev_keep) begin
                n_entry = i_ctl.new_job;
            end else begin
                n_entry = i_prev_entry;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

`default_nettype wire
